>>> sv/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg: shared types and constants of the IMU bias removal calibrator
// Holds the transaction payload structs, the command and stage codes, the
// axis numbering of the offset bank and the gravity register reset value.
// ----------------------------------------------------------------------------
package ibc_pkg;

    // Number of sensor axes and axes per calibration stage
    localparam int NUM_AXES  = 9;
    localparam int NUM_LANES = 3;

    // Reset value of the accelerometer gravity register (counts for one g)
    localparam logic [14:0] GRAVITY_RESET = 15'd8196;

    // Offset bank order: accel XYZ, gyro XYZ, mag XYZ
    localparam int AX_ACCEL_X = 0;
    localparam int AX_ACCEL_Y = 1;
    localparam int AX_ACCEL_Z = 2;
    localparam int AX_GYRO_X  = 3;
    localparam int AX_GYRO_Y  = 4;
    localparam int AX_GYRO_Z  = 5;
    localparam int AX_MAG_X   = 6;
    localparam int AX_MAG_Y   = 7;
    localparam int AX_MAG_Z   = 8;

    // Command carried by an input transaction
    typedef enum logic [1:0] {
        FUNC_SAMPLE      = 2'd0,
        FUNC_START_GYRO  = 2'd1,
        FUNC_START_ACCEL = 2'd2,
        FUNC_START_ALL   = 2'd3
    } t_func;

    // Calibration stage
    typedef enum logic [1:0] {
        STAGE_IDLE  = 2'd0,
        STAGE_GYRO  = 2'd1,
        STAGE_ACCEL = 2'd2,
        STAGE_MAG   = 2'd3
    } t_stage;

    typedef struct packed {
        t_func              func;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] accel_x_out;
        logic signed [15:0] accel_y_out;
        logic signed [15:0] accel_z_out;
        logic signed [15:0] gyro_x_out;
        logic signed [15:0] gyro_y_out;
        logic signed [15:0] gyro_z_out;
        logic signed [15:0] mag_x_out;
        logic signed [15:0] mag_y_out;
        logic signed [15:0] mag_z_out;
        t_stage             cal_phase;
        t_stage             cal_finished;
    } t_out_item;

    // Status of one step, from the calibration engine to the result register
    typedef struct packed {
        t_stage phase;
        t_stage finished;
    } t_cal_status;

    typedef logic [NUM_AXES-1:0][15:0] t_offsets;

    // Stage that owns an axis of the offset bank
    function automatic t_stage axis_owner(input int ax);
        t_stage owner;
        if (ax < 3) begin
            owner = STAGE_ACCEL;
        end else if (ax < 6) begin
            owner = STAGE_GYRO;
        end else begin
            owner = STAGE_MAG;
        end
        return owner;
    endfunction

    // Lane of the running sums that feeds an axis
    function automatic int axis_lane(input int ax);
        int lane;
        if (ax < 3) begin
            lane = ax;
        end else if (ax < 6) begin
            lane = ax - 3;
        end else begin
            lane = ax - 6;
        end
        return lane;
    endfunction

endpackage

>>> sv/imu_bias_removal_calibrator.sv
// ----------------------------------------------------------------------------
// imu_bias_removal_calibrator: nine-axis IMU offset removal and calibration
// Subtracts per-axis offsets from each sample and runs the chained gyro,
// accel and magnetometer zero-offset averaging stages on command.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_item): a sample transaction
//   (func = sample) yields one result; a start command yields none and begins
//   calibration only while idle. Start-all behaves as a gyro start.
//   Output channel (o_out_valid / i_out_ready / o_out_item): corrected axes,
//   the calibration phase after the sample and the stage finished by it.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data): accel Z
//   counts for one g; always ready, write only while no transaction is in
//   flight.
//   Throughput: one transaction per clock while i_out_ready holds high, set
//   by the single input register and single result register around the
//   subtract, sum and divide logic.
//   Reset (synchronous, active low) clears offsets, sums, counter and stage
//   and loads the gravity register with its default; no clearing pass.
//   When the receiver stalls, the result register holds and one more
//   transaction is taken into the input register before o_in_ready drops.
// ----------------------------------------------------------------------------
module imu_bias_removal_calibrator #(
    parameter int CAL_COUNT = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ibc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ibc_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_data
);

    import ibc_pkg::*;

    logic        r_in_valid, n_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;
    logic [14:0] r_gravity;
    logic        in_take;
    logic        is_cmd;
    logic        advance;
    logic        out_load;
    t_offsets    offsets;
    t_cal_status status;

    // Handshake control
    assign is_cmd     = (r_in_item.func != FUNC_SAMPLE);
    assign advance    = r_in_valid && (is_cmd || !r_out_valid || i_out_ready);
    assign out_load   = advance && !is_cmd;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_in_valid  = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Gravity register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gravity <= i_cfg_data;
        end
    end

    ibc_cal_engine #(
        .CAL_COUNT (CAL_COUNT)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_item    (r_in_item),
        .i_gravity (r_gravity),
        .o_offsets (offsets),
        .o_status  (status)
    );

    // Subtract the offsets held before this sample
    always_comb begin
        n_out_item.accel_x_out  = r_in_item.accel_x - offsets[AX_ACCEL_X];
        n_out_item.accel_y_out  = r_in_item.accel_y - offsets[AX_ACCEL_Y];
        n_out_item.accel_z_out  = r_in_item.accel_z - offsets[AX_ACCEL_Z];
        n_out_item.gyro_x_out   = r_in_item.gyro_x  - offsets[AX_GYRO_X];
        n_out_item.gyro_y_out   = r_in_item.gyro_y  - offsets[AX_GYRO_Y];
        n_out_item.gyro_z_out   = r_in_item.gyro_z  - offsets[AX_GYRO_Z];
        n_out_item.mag_x_out    = r_in_item.mag_x   - offsets[AX_MAG_X];
        n_out_item.mag_y_out    = r_in_item.mag_y   - offsets[AX_MAG_Y];
        n_out_item.mag_z_out    = r_in_item.mag_z   - offsets[AX_MAG_Z];
        n_out_item.cal_phase    = status.phase;
        n_out_item.cal_finished = status.finished;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sv/ibc_const_div.sv
// ----------------------------------------------------------------------------
// ibc_const_div: signed divide of a running sum by the sample count
// Truncates toward zero and wraps the quotient to 16 bits. The magnitude is
// multiplied by a rounded-up reciprocal; the error bound of that reciprocal
// keeps the floored product exact over the whole sum range, so no correction
// step follows.
// ----------------------------------------------------------------------------
module ibc_const_div #(
    parameter  int CAL_COUNT = 200,
    localparam int SUM_W     = $clog2(CAL_COUNT) + 17
) (
    input  logic [SUM_W-1:0] i_dividend,
    output logic [15:0]      o_quotient
);

    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + $clog2(CAL_COUNT);
    localparam int RECIP_W = MAG_W + 2;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic              neg;
    logic [SUM_W-1:0]  abs_full;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [15:0]       quot_mag;

    // Take the magnitude; it always fits below the sign bit
    assign neg      = i_dividend[SUM_W-1];
    assign abs_full = neg ? (SUM_W'(0) - i_dividend) : i_dividend;
    assign mag      = abs_full[MAG_W-1:0];

    // Multiply by the reciprocal and keep the integer part
    assign prod     = PROD_W'(mag) * PROD_W'(RECIP);
    assign quot_mag = prod[SHIFT +: 16];

    // Restore the sign
    assign o_quotient = neg ? (16'd0 - quot_mag) : quot_mag;

endmodule

>>> sv/ibc_cal_engine.sv
// ----------------------------------------------------------------------------
// ibc_cal_engine: calibration sequencer, running sums and offset bank
// Steps once per transaction leaving the input register. Runs the chained
// gyro, accel and magnetometer averaging stages and holds the nine offsets.
// ----------------------------------------------------------------------------
module ibc_cal_engine #(
    parameter  int CAL_COUNT = 200,
    localparam int SUM_W     = $clog2(CAL_COUNT) + 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  ibc_pkg::t_in_item     i_item,
    input  logic [14:0]           i_gravity,
    output ibc_pkg::t_offsets     o_offsets,
    output ibc_pkg::t_cal_status  o_status
);

    import ibc_pkg::*;

    localparam int CNT_W = $clog2(CAL_COUNT + 1);

    t_stage                  r_stage, n_stage;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SUM_W-1:0]        r_sum    [NUM_LANES];
    logic [SUM_W-1:0]        n_sum    [NUM_LANES];
    logic [SUM_W-1:0]        sum_add  [NUM_LANES];
    logic signed [16:0]      samp     [NUM_LANES];
    logic [15:0]             quot     [NUM_LANES];
    logic [15:0]             r_offset [NUM_AXES];
    logic [15:0]             n_offset [NUM_AXES];
    logic signed [16:0]      az_adj;
    logic [CNT_W-1:0]        count_inc;
    logic                    is_sample;
    logic                    done;
    logic                    clear_en;
    t_stage                  clear_stage;
    logic                    load_en;
    logic                    sum_clear;
    logic                    sum_acc;
    t_stage                  fin;

    assign is_sample = (i_item.func == FUNC_SAMPLE);
    assign count_inc = r_count + CNT_W'(1);
    assign done      = (count_inc == CNT_W'(CAL_COUNT));

    // Remove one g from accel Z while it is summed
    assign az_adj = {i_item.accel_z[15], i_item.accel_z} - {2'b00, i_gravity};

    // Pick the three axes of the running stage
    always_comb begin
        unique case (r_stage)
            STAGE_GYRO: begin
                samp[0] = 17'(i_item.gyro_x);
                samp[1] = 17'(i_item.gyro_y);
                samp[2] = 17'(i_item.gyro_z);
            end
            STAGE_ACCEL: begin
                samp[0] = 17'(i_item.accel_x);
                samp[1] = 17'(i_item.accel_y);
                samp[2] = az_adj;
            end
            STAGE_MAG, STAGE_IDLE: begin
                samp[0] = 17'(i_item.mag_x);
                samp[1] = 17'(i_item.mag_y);
                samp[2] = 17'(i_item.mag_z);
            end
        endcase
    end

    // Accumulate and divide, one lane per axis of a stage
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign sum_add[g] = r_sum[g] + {{(SUM_W-17){samp[g][16]}}, samp[g]};

        ibc_const_div #(
            .CAL_COUNT (CAL_COUNT)
        ) u_div (
            .i_dividend (sum_add[g]),
            .o_quotient (quot[g])
        );
    end

    // Sequence the stages
    always_comb begin
        n_stage     = r_stage;
        n_count     = r_count;
        clear_en    = 1'b0;
        clear_stage = r_stage;
        load_en     = 1'b0;
        sum_clear   = 1'b0;
        sum_acc     = 1'b0;
        fin         = STAGE_IDLE;
        if (i_step) begin
            if (!is_sample) begin
                // Start command: take it only while idle
                if (r_stage == STAGE_IDLE) begin
                    n_stage = (i_item.func == FUNC_START_ACCEL) ? STAGE_ACCEL : STAGE_GYRO;
                    n_count = '0;
                end
            end else if (r_stage != STAGE_IDLE) begin
                if (r_count == '0) begin
                    // First sample of a stage: clear its offsets and the sums
                    clear_en  = 1'b1;
                    sum_clear = 1'b1;
                    n_count   = CNT_W'(1);
                end else begin
                    sum_acc = 1'b1;
                    n_count = count_inc;
                    if (done) begin
                        load_en = 1'b1;
                        fin     = r_stage;
                        unique case (r_stage)
                            STAGE_GYRO: begin
                                n_stage     = STAGE_ACCEL;
                                clear_en    = 1'b1;
                                clear_stage = STAGE_ACCEL;
                                sum_clear   = 1'b1;
                                n_count     = CNT_W'(1);
                            end
                            STAGE_ACCEL: begin
                                n_stage     = STAGE_MAG;
                                clear_en    = 1'b1;
                                clear_stage = STAGE_MAG;
                                sum_clear   = 1'b1;
                                n_count     = CNT_W'(1);
                            end
                            STAGE_MAG: begin
                                n_stage   = STAGE_IDLE;
                                n_count   = '0;
                                sum_clear = 1'b1;
                            end
                            STAGE_IDLE: begin
                                n_stage = STAGE_IDLE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Next sums
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            if (sum_clear) begin
                n_sum[k] = '0;
            end else if (sum_acc) begin
                n_sum[k] = sum_add[k];
            end else begin
                n_sum[k] = r_sum[k];
            end
        end
    end

    // Next offsets: load the finished stage, clear the starting one
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (load_en && (axis_owner(k) == r_stage)) begin
                n_offset[k] = quot[axis_lane(k)];
            end else if (clear_en && (axis_owner(k) == clear_stage)) begin
                n_offset[k] = '0;
            end else begin
                n_offset[k] = r_offset[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= STAGE_IDLE;
            r_count <= '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_sum[k] <= '0;
            end
            for (int k = 0; k < NUM_AXES; k++) begin
                r_offset[k] <= '0;
            end
        end else begin
            r_stage <= n_stage;
            r_count <= n_count;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_sum[k] <= n_sum[k];
            end
            for (int k = 0; k < NUM_AXES; k++) begin
                r_offset[k] <= n_offset[k];
            end
        end
    end

    // Present the offsets held before this step, and the step's status
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            o_offsets[k] = r_offset[k];
        end
    end

    assign o_status.phase    = n_stage;
    assign o_status.finished = fin;

    // Idle means nothing is left in the counter or the sums
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == STAGE_IDLE) |->
            (r_count == '0 && r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0))
        else $error("calibrator idle with residual count or sums");

    // The counter never reaches the sample count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(CAL_COUNT))
        else $error("calibration counter out of range");

    // A finished gyro stage hands over to a freshly started accel stage
    a_gyro_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin == STAGE_GYRO) |=>
            (r_stage == STAGE_ACCEL && r_count == CNT_W'(1) && r_sum[0] == '0))
        else $error("gyro stage did not hand over to accel stage");

    // A stage finishes only on a sample that completes its count
    a_finish_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin != STAGE_IDLE) |-> (i_step && is_sample && done && fin == r_stage))
        else $error("stage finish without a completing sample");

endmodule

>>> tb/sv/imu_bias_removal_calibrator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_removal_calibrator_tb: self-checking bench of the IMU calibrator
// Streams sample and start-command transactions through the block under
// random valid/ready pressure. A transaction-level tracker of offsets, sums and
// calibration stage predicts every result, and the monitor checks each field.
// The gravity register is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module imu_bias_removal_calibrator_tb;
    import ibc_pkg::*;

    localparam int CAL_COUNT    = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 100;

    // Clock, reset and block ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data  = '0;

    // Predicted block state
    logic [15:0] bias_ofs [NUM_AXES] = '{default: '0};
    int          cal_sums [NUM_LANES] = '{default: 0};
    logic [7:0]  cal_count = '0;
    t_stage      cal_stage = STAGE_IDLE;
    logic [14:0] gravity_counts = GRAVITY_RESET;

    // Stimulus and checking bookkeeping
    t_in_item  in_pending[$];
    t_out_item expected_corrected[$];
    int        items_queued  = 0;
    int        items_taken   = 0;
    int        in_gap        = 0;
    int        out_hold      = 0;
    int        in_idle_max   = 16;
    int        out_stall_max = 16;
    int        fail_count    = 0;
    int        cycle_count   = 0;

    imu_bias_removal_calibrator #(
        .CAL_COUNT(CAL_COUNT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // First offset-bank axis owned by a stage
    function automatic int stage_first_axis(input t_stage s);
        int ax;
        case (s)
            STAGE_GYRO: begin
                ax = AX_GYRO_X;
            end
            STAGE_ACCEL: begin
                ax = AX_ACCEL_X;
            end
            default: begin
                ax = AX_MAG_X;
            end
        endcase
        return ax;
    endfunction

    // Clear the current stage's offsets and sums; its first sample counts as one
    task automatic open_stage();
        int base;
        base = stage_first_axis(cal_stage);
        for (int k = 0; k < NUM_LANES; k++) begin
            bias_ofs[base + k] = '0;
            cal_sums[k] = 0;
        end
        cal_count = 8'd1;
    endtask

    // Advance the tracked state by one accepted transaction
    task automatic track_bias_removal(input t_in_item it);
        logic [15:0] raw [NUM_AXES];
        t_out_item   res;
        t_stage      done;
        int          base;
        int          v;
        raw[AX_ACCEL_X] = it.accel_x;
        raw[AX_ACCEL_Y] = it.accel_y;
        raw[AX_ACCEL_Z] = it.accel_z;
        raw[AX_GYRO_X]  = it.gyro_x;
        raw[AX_GYRO_Y]  = it.gyro_y;
        raw[AX_GYRO_Z]  = it.gyro_z;
        raw[AX_MAG_X]   = it.mag_x;
        raw[AX_MAG_Y]   = it.mag_y;
        raw[AX_MAG_Z]   = it.mag_z;
        done = STAGE_IDLE;
        if (it.func != FUNC_SAMPLE) begin
            // start commands only take effect while idle
            if (cal_stage == STAGE_IDLE) begin
                cal_stage = (it.func == FUNC_START_ACCEL) ? STAGE_ACCEL : STAGE_GYRO;
                cal_count = '0;
            end
        end else begin
            // correction uses the offsets held before this sample
            res.accel_x_out = raw[AX_ACCEL_X] - bias_ofs[AX_ACCEL_X];
            res.accel_y_out = raw[AX_ACCEL_Y] - bias_ofs[AX_ACCEL_Y];
            res.accel_z_out = raw[AX_ACCEL_Z] - bias_ofs[AX_ACCEL_Z];
            res.gyro_x_out  = raw[AX_GYRO_X]  - bias_ofs[AX_GYRO_X];
            res.gyro_y_out  = raw[AX_GYRO_Y]  - bias_ofs[AX_GYRO_Y];
            res.gyro_z_out  = raw[AX_GYRO_Z]  - bias_ofs[AX_GYRO_Z];
            res.mag_x_out   = raw[AX_MAG_X]   - bias_ofs[AX_MAG_X];
            res.mag_y_out   = raw[AX_MAG_Y]   - bias_ofs[AX_MAG_Y];
            res.mag_z_out   = raw[AX_MAG_Z]   - bias_ofs[AX_MAG_Z];
            if (cal_stage != STAGE_IDLE) begin
                if (cal_count == 0) begin
                    open_stage();
                end else begin
                    // accumulate, removing one g from accel Z
                    base = stage_first_axis(cal_stage);
                    for (int k = 0; k < NUM_LANES; k++) begin
                        v = $signed(raw[base + k]);
                        if (cal_stage == STAGE_ACCEL && k == 2) begin
                            v = v - int'(gravity_counts);
                        end
                        cal_sums[k] = cal_sums[k] + v;
                    end
                    cal_count++;
                    if (cal_count >= CAL_COUNT) begin
                        // average truncates toward zero, then wraps to 16 bits
                        for (int k = 0; k < NUM_LANES; k++) begin
                            bias_ofs[base + k] = 16'(cal_sums[k] / CAL_COUNT);
                        end
                        done = cal_stage;
                        if (cal_stage == STAGE_GYRO) begin
                            cal_stage = STAGE_ACCEL;
                            open_stage();
                        end else if (cal_stage == STAGE_ACCEL) begin
                            cal_stage = STAGE_MAG;
                            open_stage();
                        end else begin
                            cal_stage = STAGE_IDLE;
                            cal_count = '0;
                            cal_sums  = '{default: 0};
                        end
                    end
                end
            end
            res.cal_phase    = cal_stage;
            res.cal_finished = done;
            expected_corrected.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: present pending transactions with a random gap between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                track_bias_removal(in_item);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (in_pending.size() > 0) begin
                    in_item  <= in_pending.pop_front();
                    in_valid <= 1'b1;
                    in_gap = $urandom_range(0, in_idle_max);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall each result at random, then check it against the oldest one
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_corrected.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_corrected.pop_front();
                    check_field("accel_x_out", want.accel_x_out, out_item.accel_x_out);
                    check_field("accel_y_out", want.accel_y_out, out_item.accel_y_out);
                    check_field("accel_z_out", want.accel_z_out, out_item.accel_z_out);
                    check_field("gyro_x_out", want.gyro_x_out, out_item.gyro_x_out);
                    check_field("gyro_y_out", want.gyro_y_out, out_item.gyro_y_out);
                    check_field("gyro_z_out", want.gyro_z_out, out_item.gyro_z_out);
                    check_field("mag_x_out", want.mag_x_out, out_item.mag_x_out);
                    check_field("mag_y_out", want.mag_y_out, out_item.mag_y_out);
                    check_field("mag_z_out", want.mag_z_out, out_item.mag_z_out);
                    check_field("cal_phase", {14'd0, want.cal_phase},
                                {14'd0, out_item.cal_phase});
                    check_field("cal_finished", {14'd0, want.cal_finished},
                                {14'd0, out_item.cal_finished});
                end
                out_hold = $urandom_range(0, out_stall_max);
            end else if (out_valid && out_hold > 0) begin
                out_hold--;
            end
            out_ready <= (out_hold == 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("imu_bias_removal_calibrator verification failed");
            $finish;
        end
    end

    task automatic push_uniform(input t_func f, input logic [15:0] v);
        t_in_item it;
        it = '{f, v, v, v, v, v, v, v, v, v};
        in_pending.push_back(it);
        items_queued++;
    endtask

    // Extremes and random values, or a sensor-like level with small noise
    function automatic logic [15:0] draw_axis(input int mode, input logic [15:0] level);
        logic [15:0] v;
        int          pick;
        pick = $urandom_range(0, 19);
        if (mode != 0) begin
            v = level + 16'($urandom_range(0, 511)) - 16'd256;
        end else if (pick == 0) begin
            v = 16'h8000;
        end else if (pick == 1) begin
            v = 16'h7fff;
        end else if (pick == 2) begin
            v = 16'h0000;
        end else begin
            v = 16'($urandom);
        end
        return v;
    endfunction

    // Hold until every transaction is taken and every result checked
    task automatic wait_drained();
        do @(posedge clk);
        while (items_taken != items_queued || expected_corrected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gravity(input logic [14:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gravity_counts = v;
    endtask

    initial begin
        t_in_item    it;
        logic [15:0] level [NUM_AXES];
        int          mode;
        logic [14:0] grav;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes while idle, start-all from idle, ignored restarts
        push_uniform(FUNC_SAMPLE, 16'h0000);
        push_uniform(FUNC_SAMPLE, 16'h7fff);
        push_uniform(FUNC_SAMPLE, 16'h8000);
        push_uniform(FUNC_SAMPLE, 16'h5555);
        push_uniform(FUNC_SAMPLE, 16'haaaa);
        push_uniform(FUNC_START_ALL, 16'hffff);
        push_uniform(FUNC_SAMPLE, 16'h7fff);
        push_uniform(FUNC_SAMPLE, 16'h8000);
        push_uniform(FUNC_START_ACCEL, 16'h1234);
        push_uniform(FUNC_START_GYRO, 16'h0000);
        push_uniform(FUNC_START_ALL, 16'h8000);
        push_uniform(FUNC_SAMPLE, 16'hffff);
        push_uniform(FUNC_SAMPLE, 16'h0001);
        push_uniform(FUNC_SAMPLE, 16'h7fff);
        wait_drained();

        // Random phases: new gravity setting and pressure mix per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    grav = 15'd0;
                end
                1: begin
                    grav = 15'h7fff;
                end
                2: begin
                    grav = 15'($urandom);
                end
                default: begin
                    grav = GRAVITY_RESET;
                end
            endcase
            write_gravity(grav);
            in_idle_max   = (p % 3 == 0) ? 0 : 16;
            out_stall_max = (p % 3 == 1) ? 0 : 16;
            mode = $urandom_range(0, 1);
            foreach (level[k]) begin
                level[k] = 16'($urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 92) begin
                    it.func = FUNC_SAMPLE;
                end else begin
                    it.func = t_func'(2'($urandom_range(1, 3)));
                end
                it.accel_x = draw_axis(mode, level[AX_ACCEL_X]);
                it.accel_y = draw_axis(mode, level[AX_ACCEL_Y]);
                it.accel_z = draw_axis(mode, level[AX_ACCEL_Z]);
                it.gyro_x  = draw_axis(mode, level[AX_GYRO_X]);
                it.gyro_y  = draw_axis(mode, level[AX_GYRO_Y]);
                it.gyro_z  = draw_axis(mode, level[AX_GYRO_Z]);
                it.mag_x   = draw_axis(mode, level[AX_MAG_X]);
                it.mag_y   = draw_axis(mode, level[AX_MAG_Y]);
                it.mag_z   = draw_axis(mode, level[AX_MAG_Z]);
                in_pending.push_back(it);
                items_queued++;
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("imu_bias_removal_calibrator verification clean");
        end else begin
            $display("imu_bias_removal_calibrator verification failed");
        end
        $finish;
    end

endmodule
